// File: sv/ps2hc_pkg.sv
`default_nettype none
package ps2hc_pkg;

  localparam int RING_DEPTH      = 64;
  localparam int COMMAND_BYTES   = 4;
  localparam int INPUT_CMD_SLOTS = 4;

  localparam int CMD_SLOTS  = (COMMAND_BYTES < INPUT_CMD_SLOTS) ? COMMAND_BYTES
                                                                : INPUT_CMD_SLOTS;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int HELD_W     = $clog2(RING_DEPTH + 1);
  localparam int CMD_CNT_W  = $clog2(COMMAND_BYTES + 1);
  localparam int CMD_IDX_W  = (COMMAND_BYTES > 1) ? $clog2(COMMAND_BYTES) : 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] RESEND_BYTE = 8'hFE;
  localparam logic [7:0] PREFIX_E0   = 8'hE0;
  localparam logic [7:0] PREFIX_F0   = 8'hF0;
  localparam logic [7:0] PREFIX_E1   = 8'hE1;

  localparam logic [2:0] RETRY_LIMIT_RESET = 3'd5;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RX      = 2'd1,
    OP_REFUSED = 2'd2,
    OP_POP     = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RETRY_LIMIT   = 1'b0,
    REG_KEYBOARD_MODE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] cmd_byte_0;
    logic [7:0] cmd_byte_1;
    logic [7:0] cmd_byte_2;
    logic [7:0] cmd_byte_3;
    logic [2:0] cmd_length;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       done_valid;
    logic       done_status;
    logic       wake;
    logic       pop_valid;
    logic [7:0] pop_byte;
    logic       buffer_empty;
    logic       dropped;
  } out_item_t;

  function automatic logic is_prefix(input logic [7:0] b);
    return (b == PREFIX_E0) || (b == PREFIX_F0) || (b == PREFIX_E1);
  endfunction

endpackage
`default_nettype wire

// File: sv/ps2hc_ram.sv
`default_nettype none
module ps2hc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/ps2_host_command_ack_engine_core.sv
`default_nettype none
// PS/2 host command/ack engine. Each transfer on the input channel is one
// operation (start a command, device byte received, transmit refused, pop a
// buffered byte) and yields exactly one result transfer. The state update and
// the result of an operation are computed from the accepted transfer and
// land in the output register, so one operation per cycle is sustained while
// the result side keeps taking transfers; a held result blocks new input only
// when the output register is still full.
// Device bytes other than an ack/resend during a command go to a 64-entry ring
// buffer RAM whose head entry is prefetched every cycle, so a pop takes the head byte from the prefetched read data.
// There is no clearing pass after reset; cfg writes must happen while idle.
module ps2_host_command_ack_engine_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ps2hc_pkg::in_item_t           in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ps2hc_pkg::out_item_t               out_data,
  input  wire logic                          cfg_we,
  input  wire logic [ps2hc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ps2hc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ps2hc_pkg::*;

  logic [2:0]           retry_limit_r;
  logic                 kb_mode_r;

  logic [RING_AW-1:0]   rd_ptr_r, rd_ptr_nxt, ram_raddr;
  logic [RING_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic                 full_r, full_nxt;
  logic [HELD_W-1:0]    held_r, held_nxt, held_inc;
  logic                 wake_pend_r, wake_pend_nxt;

  logic [7:0]           cmd_store_r [COMMAND_BYTES];
  logic [7:0]           start_bytes [COMMAND_BYTES];
  logic [7:0]           in_bytes    [INPUT_CMD_SLOTS];
  logic [CMD_CNT_W-1:0] cmd_len_r, cmd_len_nxt, start_len;
  logic [CMD_CNT_W-1:0] acked_r, acked_nxt, acked_inc;
  logic [2:0]           resend_r, resend_nxt, resend_inc;
  logic [2:0]           refusal_r, refusal_nxt, refusal_inc;
  logic                 busy_r, busy_nxt;

  logic                 out_valid_r;
  out_item_t            out_data_r, res;

  logic                 accept, start_en, ring_we, ring_empty;
  logic [7:0]           cur_byte, next_byte, head_byte, ram_rdata;
  logic                 byp_r;
  logic [7:0]           byp_data_r;
  op_t                  op;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign op = op_t'(in_data.operation);

  assign in_bytes[0] = in_data.cmd_byte_0;
  assign in_bytes[1] = in_data.cmd_byte_1;
  assign in_bytes[2] = in_data.cmd_byte_2;
  assign in_bytes[3] = in_data.cmd_byte_3;

  always_comb begin
    for (int i = 0; i < COMMAND_BYTES; i++) begin
      start_bytes[i] = (i < INPUT_CMD_SLOTS) ? in_bytes[i % INPUT_CMD_SLOTS] : 8'h00;
    end
  end

  // length 0 counts as 1, anything above the slot count is clipped
  always_comb begin
    if (in_data.cmd_length == 3'd0) begin
      start_len = CMD_CNT_W'(1);
    end else if (int'(in_data.cmd_length) > CMD_SLOTS) begin
      start_len = CMD_CNT_W'(CMD_SLOTS);
    end else begin
      start_len = CMD_CNT_W'(in_data.cmd_length);
    end
  end

  assign acked_inc   = acked_r + CMD_CNT_W'(1);
  assign resend_inc  = resend_r + 3'd1;
  assign refusal_inc = refusal_r + 3'd1;
  assign held_inc    = held_r + HELD_W'(1);

  assign cur_byte  = (int'(acked_r) < COMMAND_BYTES) ?
                     cmd_store_r[acked_r[CMD_IDX_W-1:0]] : 8'h00;
  assign next_byte = (int'(acked_inc) < COMMAND_BYTES) ?
                     cmd_store_r[acked_inc[CMD_IDX_W-1:0]] : 8'h00;

  assign ring_empty = !full_r && (rd_ptr_r == wr_ptr_r);
  assign head_byte  = byp_r ? byp_data_r : ram_rdata;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
    return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + RING_AW'(1);
  endfunction

  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    full_nxt      = full_r;
    held_nxt      = held_r;
    wake_pend_nxt = wake_pend_r;
    cmd_len_nxt   = cmd_len_r;
    acked_nxt     = acked_r;
    resend_nxt    = resend_r;
    refusal_nxt   = refusal_r;
    busy_nxt      = busy_r;
    start_en      = 1'b0;
    ring_we       = 1'b0;
    res           = '0;

    case (op)
      OP_START: begin
        start_en       = 1'b1;
        cmd_len_nxt    = start_len;
        acked_nxt      = '0;
        resend_nxt     = '0;
        refusal_nxt    = '0;
        busy_nxt       = 1'b1;
        res.send_valid = 1'b1;
        res.send_byte  = in_data.cmd_byte_0;
      end
      OP_RX: begin
        if (busy_r && in_data.rx_byte == ACK_BYTE) begin
          resend_nxt  = '0;
          refusal_nxt = '0;
          if (acked_inc >= cmd_len_r) begin
            busy_nxt        = 1'b0;
            cmd_len_nxt     = '0;
            acked_nxt       = '0;
            res.done_valid  = 1'b1;
            res.done_status = STATUS_OK;
          end else begin
            acked_nxt      = acked_inc;
            res.send_valid = 1'b1;
            res.send_byte  = next_byte;
          end
        end else if (busy_r && in_data.rx_byte == RESEND_BYTE) begin
          if (resend_inc >= retry_limit_r) begin
            busy_nxt        = 1'b0;
            cmd_len_nxt     = '0;
            acked_nxt       = '0;
            resend_nxt      = '0;
            refusal_nxt     = '0;
            res.done_valid  = 1'b1;
            res.done_status = STATUS_TIMEOUT;
          end else begin
            resend_nxt     = resend_inc;
            res.send_valid = 1'b1;
            res.send_byte  = cur_byte;
          end
        end else if (full_r) begin
          res.dropped = 1'b1;
        end else begin
          ring_we    = 1'b1;
          wr_ptr_nxt = ring_next(wr_ptr_r);
          full_nxt   = (ring_next(wr_ptr_r) == rd_ptr_r);
          if (!is_prefix(in_data.rx_byte)) begin
            held_nxt = held_inc;
          end
          if (kb_mode_r && !wake_pend_r && held_nxt != '0) begin
            wake_pend_nxt = 1'b1;
            res.wake      = 1'b1;
          end
        end
      end
      OP_REFUSED: begin
        if (busy_r) begin
          if (refusal_inc >= retry_limit_r) begin
            busy_nxt        = 1'b0;
            cmd_len_nxt     = '0;
            acked_nxt       = '0;
            resend_nxt      = '0;
            refusal_nxt     = '0;
            res.done_valid  = 1'b1;
            res.done_status = STATUS_TIMEOUT;
          end else begin
            refusal_nxt    = refusal_inc;
            res.send_valid = 1'b1;
            res.send_byte  = cur_byte;
          end
        end
      end
      default: begin
        wake_pend_nxt = 1'b0;
        if (!ring_empty) begin
          rd_ptr_nxt = ring_next(rd_ptr_r);
          full_nxt   = 1'b0;
          if (!is_prefix(head_byte) && held_r != '0) begin
            held_nxt = held_r - HELD_W'(1);
          end
          res.pop_valid = 1'b1;
          res.pop_byte  = head_byte;
        end
      end
    endcase

    res.buffer_empty = !full_nxt && (rd_ptr_nxt == wr_ptr_nxt);
  end

  // head of the ring is always prefetched at the pointer value of the next cycle
  assign ram_raddr = accept ? rd_ptr_nxt : rd_ptr_r;

  ps2hc_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH),
    .AW    (RING_AW)
  ) u_ring (
    .clk   (clk),
    .we    (accept && ring_we),
    .waddr (wr_ptr_r),
    .wdata (in_data.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= accept && ring_we && (wr_ptr_r == ram_raddr);
    end
    byp_data_r <= in_data.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RESET;
      kb_mode_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_RETRY_LIMIT:   retry_limit_r <= cfg_wdata[2:0];
        REG_KEYBOARD_MODE: kb_mode_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      full_r      <= 1'b0;
      held_r      <= '0;
      wake_pend_r <= 1'b0;
      cmd_len_r   <= '0;
      acked_r     <= '0;
      resend_r    <= '0;
      refusal_r   <= '0;
      busy_r      <= 1'b0;
    end else if (accept) begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      full_r      <= full_nxt;
      held_r      <= held_nxt;
      wake_pend_r <= wake_pend_nxt;
      cmd_len_r   <= cmd_len_nxt;
      acked_r     <= acked_nxt;
      resend_r    <= resend_nxt;
      refusal_r   <= refusal_nxt;
      busy_r      <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_en) begin
      for (int i = 0; i < COMMAND_BYTES; i++) begin
        cmd_store_r[i] <= start_bytes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (rd_ptr_r == wr_ptr_r))
    else $error("ring full with pointers apart");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cmd_len_r == '0 && acked_r == '0 && resend_r == '0 && refusal_r == '0))
    else $error("command counters not cleared while idle");

  a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_POP && !ring_empty) |=> (rd_ptr_r != $past(rd_ptr_r)))
    else $error("pop did not advance read pointer");

  a_wake_kb: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.wake) |-> (kb_mode_r && !wake_pend_r && held_nxt != '0))
    else $error("wake raised without keyboard mode or held byte");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
module testbench;
  import ps2hc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ps2_host_command_ack_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the engine state
  logic [7:0] ring_mem [RING_DEPTH];
  logic [RING_AW-1:0] ring_rd = '0;
  logic [RING_AW-1:0] ring_wr = '0;
  logic ring_is_full = 1'b0;
  int held_nonprefix = 0;
  logic wake_armed = 1'b0;
  logic [7:0] cmd_mem [COMMAND_BYTES];
  int cmd_len = 0;
  int acked_n = 0;
  int resend_n = 0;
  int refuse_n = 0;
  logic cmd_busy = 1'b0;
  logic [2:0] retry_limit_q = RETRY_LIMIT_RESET;
  logic kbd_mode_q = 1'b0;

  in_item_t op_queue[$];
  out_item_t expected_results[$];
  int ops_queued = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int rx_share = 55;
  logic no_idle = 1'b0;
  logic in_xfer = 1'b0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int hold_left = 0;

  function automatic logic prefix_byte(input logic [7:0] b);
    return b == PREFIX_E0 || b == PREFIX_F0 || b == PREFIX_E1;
  endfunction

  function automatic void close_command(inout out_item_t r, input logic status);
    cmd_busy = 1'b0;
    cmd_len = 0;
    acked_n = 0;
    resend_n = 0;
    refuse_n = 0;
    r.done_valid = 1'b1;
    r.done_status = status;
  endfunction

  function automatic out_item_t predict_op(input in_item_t it);
    out_item_t r;
    logic [7:0] b;
    int len;
    r = '0;
    case (op_t'(it.operation))
      OP_START: begin
        len = (it.cmd_length == 0) ? 1 : int'(it.cmd_length);
        if (len > CMD_SLOTS) len = CMD_SLOTS;
        cmd_mem[0] = it.cmd_byte_0;
        cmd_mem[1] = it.cmd_byte_1;
        cmd_mem[2] = it.cmd_byte_2;
        cmd_mem[3] = it.cmd_byte_3;
        cmd_len = len;
        acked_n = 0;
        resend_n = 0;
        refuse_n = 0;
        cmd_busy = 1'b1;
        r.send_valid = 1'b1;
        r.send_byte = it.cmd_byte_0;
      end
      OP_RX: begin
        if (cmd_busy && it.rx_byte == ACK_BYTE) begin
          acked_n++;
          resend_n = 0;
          refuse_n = 0;
          if (acked_n >= cmd_len) begin
            close_command(r, STATUS_OK);
          end else begin
            r.send_valid = 1'b1;
            r.send_byte = cmd_mem[acked_n];
          end
        end else if (cmd_busy && it.rx_byte == RESEND_BYTE) begin
          resend_n++;
          if (resend_n >= retry_limit_q) begin
            close_command(r, STATUS_TIMEOUT);
          end else begin
            r.send_valid = 1'b1;
            r.send_byte = cmd_mem[acked_n];
          end
        end else if (ring_is_full) begin
          r.dropped = 1'b1;
        end else begin
          ring_mem[ring_wr] = it.rx_byte;
          ring_wr = (ring_wr == RING_DEPTH - 1) ? '0 : ring_wr + 1'b1;
          if (ring_wr == ring_rd) ring_is_full = 1'b1;
          if (!prefix_byte(it.rx_byte)) held_nonprefix++;
          if (kbd_mode_q && !wake_armed && held_nonprefix > 0) begin
            wake_armed = 1'b1;
            r.wake = 1'b1;
          end
        end
      end
      OP_REFUSED: begin
        if (cmd_busy) begin
          refuse_n++;
          if (refuse_n >= retry_limit_q) begin
            close_command(r, STATUS_TIMEOUT);
          end else begin
            r.send_valid = 1'b1;
            r.send_byte = cmd_mem[acked_n];
          end
        end
      end
      default: begin
        // pop clears the wake request even on an empty ring
        wake_armed = 1'b0;
        if (ring_is_full || ring_rd != ring_wr) begin
          b = ring_mem[ring_rd];
          ring_rd = (ring_rd == RING_DEPTH - 1) ? '0 : ring_rd + 1'b1;
          ring_is_full = 1'b0;
          if (!prefix_byte(b) && held_nonprefix > 0) held_nonprefix--;
          r.pop_valid = 1'b1;
          r.pop_byte = b;
        end
      end
    endcase
    r.buffer_empty = !ring_is_full && ring_rd == ring_wr;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch: result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Sender: valid held with a stable payload until the transfer happens
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (op_queue.size() != 0 && (no_idle || $urandom_range(99) >= 31)) begin
        in_valid <= 1'b1;
        in_data <= op_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(99) >= 31;
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want_r;
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      cycle_count++;
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want_r = expected_results.pop_front();
          check_field("send_valid", 8'(out_data.send_valid), 8'(want_r.send_valid));
          check_field("send_byte", out_data.send_byte, want_r.send_byte);
          check_field("done_valid", 8'(out_data.done_valid), 8'(want_r.done_valid));
          check_field("done_status", 8'(out_data.done_status),
                      8'(want_r.done_status));
          check_field("wake", 8'(out_data.wake), 8'(want_r.wake));
          check_field("pop_valid", 8'(out_data.pop_valid), 8'(want_r.pop_valid));
          check_field("pop_byte", out_data.pop_byte, want_r.pop_byte);
          check_field("buffer_empty", 8'(out_data.buffer_empty),
                      8'(want_r.buffer_empty));
          check_field("dropped", 8'(out_data.dropped), 8'(want_r.dropped));
        end
      end
      if (in_valid && in_ready) expected_results.push_back(predict_op(in_data));
      in_xfer <= in_valid && in_ready;
    end
  end

  function automatic in_item_t make_op(input op_t op, input logic [7:0] rx);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.operation = op;
    it.rx_byte = rx;
    return it;
  endfunction

  task automatic queue_op(input in_item_t it);
    op_queue.push_back(it);
    ops_queued++;
  endtask

  task automatic queue_start(input logic [2:0] len, input logic [31:0] bytes);
    in_item_t it;
    it = make_op(OP_START, 8'($urandom));
    it.cmd_length = len;
    {it.cmd_byte_0, it.cmd_byte_1, it.cmd_byte_2, it.cmd_byte_3} = bytes;
    queue_op(it);
  endtask

  function automatic in_item_t noise_op();
    int r;
    int k;
    r = $urandom_range(99);
    if (r < rx_share) begin
      k = $urandom_range(9);
      if (k < 2) return make_op(OP_RX, PREFIX_E0);
      if (k == 2) return make_op(OP_RX, PREFIX_F0);
      if (k == 3) return make_op(OP_RX, PREFIX_E1);
      return make_op(OP_RX, 8'($urandom));
    end
    if (r < rx_share + 5) return make_op(OP_REFUSED, 8'($urandom));
    return make_op(OP_POP, 8'($urandom));
  endfunction

  // One command exchange: start, then per byte some resends/refusals and an ack
  task automatic queue_command();
    in_item_t it;
    int nbytes;
    int tries;
    it = make_op(OP_START, 8'($urandom));
    if ($urandom_range(9) != 0) it.cmd_length = 3'($urandom_range(4, 1));
    queue_op(it);
    nbytes = (it.cmd_length == 0) ? 1 : int'(it.cmd_length);
    if (nbytes > CMD_SLOTS) nbytes = CMD_SLOTS;
    for (int b = 0; b < nbytes; b++) begin
      tries = $urandom_range(retry_limit_q + 1);
      for (int k = 0; k < tries; k++) begin
        if ($urandom_range(3) == 0) queue_op(noise_op());
        if ($urandom_range(1) == 0) queue_op(make_op(OP_RX, RESEND_BYTE));
        else queue_op(make_op(OP_REFUSED, 8'($urandom)));
      end
      if ($urandom_range(3) == 0) queue_op(noise_op());
      // broken sequence: left hanging, the next start abandons it
      if ($urandom_range(19) == 0) return;
      queue_op(make_op(OP_RX, ACK_BYTE));
    end
  endtask

  task automatic queue_traffic(input int n);
    int stop_at;
    stop_at = ops_queued + n;
    while (ops_queued < stop_at) begin
      if ($urandom_range(99) < 55) queue_command();
      else queue_op(noise_op());
    end
  endtask

  task automatic wait_idle();
    while (op_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RETRY_LIMIT) retry_limit_q = val;
    else kbd_mode_q = val[0];
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: protocol bytes while idle, wake, length limits, retries
    cfg_write(REG_RETRY_LIMIT, 3'd2);
    cfg_write(REG_KEYBOARD_MODE, 3'd1);
    queue_op(make_op(OP_POP, 8'($urandom)));
    queue_op(make_op(OP_REFUSED, 8'($urandom)));
    queue_op(make_op(OP_RX, PREFIX_E0));
    queue_op(make_op(OP_RX, ACK_BYTE));
    queue_op(make_op(OP_RX, RESEND_BYTE));
    queue_op(make_op(OP_POP, 8'($urandom)));
    queue_op(make_op(OP_RX, PREFIX_F0));
    queue_start(3'd0, 32'h0000_0000);
    queue_op(make_op(OP_RX, ACK_BYTE));
    queue_start(3'd7, 32'hFFFF_FFFF);
    queue_op(make_op(OP_RX, ACK_BYTE));
    queue_op(make_op(OP_RX, RESEND_BYTE));
    queue_op(make_op(OP_REFUSED, 8'($urandom)));
    repeat (3) queue_op(make_op(OP_RX, ACK_BYTE));
    queue_start(3'd2, 32'h12A5_5AC3);
    queue_start(3'd3, 32'h8001_7F40);
    repeat (2) queue_op(make_op(OP_RX, RESEND_BYTE));
    queue_start(3'd1, 32'hED02_0000);
    repeat (2) queue_op(make_op(OP_REFUSED, 8'($urandom)));
    queue_op(make_op(OP_RX, PREFIX_E1));
    queue_op(make_op(OP_POP, 8'($urandom)));
    wait_idle();

    cfg_write(REG_RETRY_LIMIT, 3'd7);
    rx_share = 55;
    queue_traffic(500);
    wait_idle();

    // ring fills and drops; long receiver hold-off stalls the input side
    cfg_write(REG_RETRY_LIMIT, 3'd1);
    cfg_write(REG_KEYBOARD_MODE, 3'd0);
    rx_share = 85;
    queue_traffic(150);
    hold_req = ~hold_req;
    queue_traffic(150);
    wait_idle();

    // zero limit: first resend or refusal ends the command
    cfg_write(REG_RETRY_LIMIT, 3'd0);
    cfg_write(REG_KEYBOARD_MODE, 3'd1);
    queue_start(3'd4, 32'hF4F5_ED00);
    queue_op(make_op(OP_RX, RESEND_BYTE));
    queue_start(3'd1, 32'hFF00_0000);
    queue_op(make_op(OP_REFUSED, 8'($urandom)));
    rx_share = 55;
    queue_traffic(200);
    wait_idle();

    cfg_write(REG_RETRY_LIMIT, 3'd3);
    no_idle = 1'b1;
    rx_share = 40;
    queue_traffic(500);
    wait_idle();
    no_idle = 1'b0;

    cfg_write(REG_RETRY_LIMIT, 3'd5);
    cfg_write(REG_KEYBOARD_MODE, 3'd0);
    rx_share = 30;
    queue_traffic(400);
    wait_idle();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: ps2_host_command_ack_engine_core.f
sv/ps2hc_pkg.sv
sv/ps2hc_ram.sv
sv/ps2_host_command_ack_engine_core.sv
tb/sv/testbench.sv
